[rtl/aopt_pkg.sv]
// aopt_pkg: constants, sequencer states, register codes and the cordic angle table
// for the arc odometry pose tracker; no dependencies
`timescale 1ns / 1ps

package aopt_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int FRAC_BITS    = 16;
	localparam int TRIG_FRAC    = 30;
	localparam int GUARD        = 8;
	localparam int MUL_ITERS    = 64;
	localparam int DIV_ITERS    = 64;
	localparam int DEG_SHIFT    = 32 - FRAC_BITS;
	localparam int CNT_W        = 7;

	localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;
	localparam logic signed [63:0] TURN_PER_PI = 64'sd683565276;
	localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
	localparam logic [63:0]        DEG_HALF    = 64'd360;

	// divide by 720 = 45 << 4: drop four bits, then multiply by ceil(2^51 / 45),
	// exact for dividends below 2^45
	localparam int          DEG_PRE         = 4;
	localparam logic [63:0] DEG_BIAS        = DEG_HALF >> DEG_PRE;
	localparam logic [63:0] DEG_RECIP       = 64'd50039995859673;
	localparam int          DEG_RECIP_SHIFT = 51;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SETP, ST_PREP, ST_DIV_ANG, ST_DIV_HALF, ST_ROT1, ST_MUL_STP,
		ST_FDIV, ST_MUL_DSF, ST_MUL_SO, ST_MUL_DFF, ST_MUL_FO, ST_MUL_LX,
		ST_MUL_LY, ST_ROT2, ST_FINISH, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		REG_FORWARD_OFFSET  = 2'd0,
		REG_SIDEWAYS_OFFSET = 2'd1,
		REG_START_X         = 2'd2,
		REG_START_Y         = 2'd3
	} cfg_reg_t;

	// atan(2^-i) in binary angle units, full turn = 2^32
	function automatic logic [31:0] atan_bau(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

[rtl/arc_odometry_pose_tracker.sv]
// arc_odometry_pose_tracker: two-wheel arc odometry with heading sensor, one shared
// iterative multiply / divide / cordic engine under a sequencer; depends on aopt_pkg
`timescale 1ns / 1ps
// sequence: set-pose beat loads the start pose; update beat with a heading change runs
//   two 64-step reciprocal multiplies for angles, a 64-step divide for sin(h)/h, seven
//   64-step shift-add multiplies and two 24-step cordic passes
// throughput: one beat at a time, set by the bit-serial engine; in_ready only in idle
// reset: arst_n clears pose, stored readings, config registers and output valid

module arc_odometry_pose_tracker import aopt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic signed [31:0] forward_count,
	input  logic signed [31:0] sideways_count,
	input  logic signed [31:0] heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// config registers
	logic signed [23:0] fwd_off_q, side_off_q;
	logic signed [31:0] start_x_q, start_y_q;

	// architectural state
	logic signed [31:0] pose_x_q, pose_y_q, last_hd_q, last_fc_q, last_sc_q;

	// latched beat and intermediates
	logic signed [31:0] fc_q, sc_q, hd_q;
	logic signed [32:0] df_q, ds_q, dh_q, sum_q;
	logic [31:0]        ang_q;
	logic signed [63:0] half_q, s_q, f_q, lx_q, ly_q;
	logic               sgn_q;

	// shared engine registers
	logic [63:0]        ma_q, mb_q, macc_q;
	logic signed [63:0] cx_q, cy_q;
	logic [31:0]        z_q;
	logic               out_valid_q;

	// engine control
	logic is_rot, is_div, is_cdiv, is_unit, unit_done, unit_iter;
	logic [CNT_W-1:0] iter_last;

	always_comb begin
		is_rot  = (state_q == ST_ROT1) || (state_q == ST_ROT2);
		is_div  = (state_q == ST_FDIV);
		is_cdiv = (state_q == ST_DIV_ANG) || (state_q == ST_DIV_HALF);
		is_unit = is_rot || is_div || is_cdiv || (state_q == ST_MUL_STP) ||
		          (state_q == ST_MUL_DSF) ||
		          (state_q == ST_MUL_SO) || (state_q == ST_MUL_DFF) ||
		          (state_q == ST_MUL_FO) || (state_q == ST_MUL_LX) ||
		          (state_q == ST_MUL_LY);
		// count 0 loads operands, then the steps, then the count after the last step stores
		iter_last = is_rot ? CNT_W'(CORDIC_STEPS) :
		            (is_div ? CNT_W'(DIV_ITERS) : CNT_W'(MUL_ITERS));
		unit_done = (cnt_q == iter_last + CNT_W'(1));
		unit_iter = (cnt_q != '0) && !unit_done;
	end

	// shift-add multiply step: low 64 bits of the product
	logic [63:0] mul_acc;
	assign mul_acc = macc_q + (mb_q[0] ? ma_q : 64'd0);

	// reciprocal quotient: full product sits in {macc, mb} after the right-shift run
	logic [63:0] deg_q;
	assign deg_q = 64'({macc_q, mb_q} >> DEG_RECIP_SHIFT);

	// restoring divide step: remainder in macc, dividend shifts out of ma as quotient enters
	logic [64:0] div_t, div_diff;
	logic        div_ge;
	always_comb begin
		div_t    = {macc_q, ma_q[63]};
		div_diff = div_t - {1'b0, mb_q};
		div_ge   = (div_t >= {1'b0, mb_q});
	end

	// cordic step
	logic [4:0]         cs_idx;
	logic signed [63:0] cs_dx, cs_dy, cx_n, cy_n;
	logic [31:0]        z_n, cs_atan;
	always_comb begin
		cs_idx  = 5'(cnt_q - CNT_W'(1));
		cs_dx   = cy_q >>> cs_idx;
		cs_dy   = cx_q >>> cs_idx;
		cs_atan = atan_bau(cs_idx);
		if (z_q[31]) begin
			cx_n = cx_q + cs_dx;
			cy_n = cy_q - cs_dy;
			z_n  = z_q + cs_atan;
		end else begin
			cx_n = cx_q - cs_dx;
			cy_n = cy_q + cs_dy;
			z_n  = z_q - cs_atan;
		end
	end

	// degrees to turn units: (|v| << (32 - frac)) + 360, pre-divided by 16 for the reciprocal
	function automatic logic [63:0] deg_dividend(input logic signed [32:0] v);
		logic [32:0] m;
		m = v[32] ? 33'(-v) : 33'(v);
		return ({31'd0, m} << (DEG_SHIFT - DEG_PRE)) + DEG_BIAS;
	endfunction

	// rotation entry: fold angles in the left half plane by a half turn
	logic [31:0] rot_z0;
	logic        rot_flip;
	always_comb begin
		rot_z0   = (state_q == ST_ROT1) ? half_q[31:0] : (32'd0 - ang_q);
		rot_flip = rot_z0[31] ^ rot_z0[30];
	end

	// final accumulate with saturation
	logic signed [63:0] add_x, add_y;
	logic signed [31:0] sat_x, sat_y;
	always_comb begin
		add_x = 64'(pose_x_q) + ((cx_q + 64'sd128) >>> GUARD);
		add_y = 64'(pose_y_q) + ((cy_q + 64'sd128) >>> GUARD);
		if (add_x > 64'sd2147483647)       sat_x = 32'sh7FFFFFFF;
		else if (add_x < -64'sd2147483648) sat_x = 32'sh80000000;
		else                               sat_x = add_x[31:0];
		if (add_y > 64'sd2147483647)       sat_y = 32'sh7FFFFFFF;
		else if (add_y < -64'sd2147483648) sat_y = 32'sh80000000;
		else                               sat_y = add_y[31:0];
	end

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = op ? ST_SETP : ST_PREP;
			ST_SETP:     state_d = ST_DONE;
			ST_PREP:     state_d = ST_DIV_ANG;
			ST_DIV_ANG:  if (unit_done) state_d = (dh_q != '0) ? ST_DIV_HALF : ST_MUL_LX;
			ST_DIV_HALF: if (unit_done) state_d = ST_ROT1;
			ST_ROT1:     if (unit_done) state_d = (half_q == '0) ? ST_MUL_DSF : ST_MUL_STP;
			ST_MUL_STP:  if (unit_done) state_d = ST_FDIV;
			ST_FDIV:     if (unit_done) state_d = ST_MUL_DSF;
			ST_MUL_DSF:  if (unit_done) state_d = ST_MUL_SO;
			ST_MUL_SO:   if (unit_done) state_d = ST_MUL_DFF;
			ST_MUL_DFF:  if (unit_done) state_d = ST_MUL_FO;
			ST_MUL_FO:   if (unit_done) state_d = ST_MUL_LX;
			ST_MUL_LX:   if (unit_done) state_d = ST_MUL_LY;
			ST_MUL_LY:   if (unit_done) state_d = ST_ROT2;
			ST_ROT2:     if (unit_done) state_d = ST_FINISH;
			ST_FINISH:   state_d = ST_DONE;
			ST_DONE:     if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		out_valid = out_valid_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			fwd_off_q   <= '0;
			side_off_q  <= '0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			last_hd_q   <= '0;
			last_fc_q   <= '0;
			last_sc_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (is_unit && state_d == state_q) ? cnt_q + CNT_W'(1) : '0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FORWARD_OFFSET:  fwd_off_q  <= cfg_data[23:0];
					REG_SIDEWAYS_OFFSET: side_off_q <= cfg_data[23:0];
					REG_START_X:         start_x_q  <= cfg_data;
					REG_START_Y:         start_y_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_SETP) begin
				pose_x_q <= start_x_q;
				pose_y_q <= start_y_q;
			end
			if (state_q == ST_FINISH) begin
				pose_x_q <= sat_x;
				pose_y_q <= sat_y;
			end
			if ((state_q == ST_SETP) || (state_q == ST_FINISH)) begin
				last_hd_q <= hd_q;
				last_fc_q <= fc_q;
				last_sc_q <= sc_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			fc_q <= forward_count;
			sc_q <= sideways_count;
			hd_q <= heading;
		end
		if (out_load) begin
			pos_x       <= pose_x_q;
			pos_y       <= pose_y_q;
			heading_out <= last_hd_q;
		end

		// operand load on the first cycle of each engine unit
		if (cnt_q == '0) begin
			unique case (state_q)
				ST_DIV_ANG: begin
					ma_q <= DEG_RECIP; mb_q <= deg_dividend(sum_q); macc_q <= '0;
				end
				ST_DIV_HALF: begin
					ma_q <= DEG_RECIP; mb_q <= deg_dividend(dh_q); macc_q <= '0;
				end
				ST_MUL_STP: begin
					ma_q <= s_q; mb_q <= TURN_PER_PI; macc_q <= '0;
				end
				ST_FDIV: begin
					ma_q   <= macc_q[63] ? 64'd0 - macc_q : macc_q;
					mb_q   <= half_q[63] ? 64'(-half_q) : 64'(half_q);
					sgn_q  <= macc_q[63] ^ half_q[63];
					macc_q <= '0;
				end
				ST_MUL_DSF: begin
					ma_q <= 64'(ds_q); mb_q <= f_q; macc_q <= '0;
				end
				ST_MUL_SO: begin
					ma_q <= 64'(side_off_q) <<< 1; mb_q <= s_q; macc_q <= '0;
				end
				ST_MUL_DFF: begin
					ma_q <= 64'(df_q); mb_q <= f_q; macc_q <= '0;
				end
				ST_MUL_FO: begin
					ma_q <= 64'(fwd_off_q) <<< 1; mb_q <= s_q; macc_q <= '0;
				end
				ST_MUL_LX: begin
					ma_q <= lx_q; mb_q <= GAIN_Q30; macc_q <= '0;
				end
				ST_MUL_LY: begin
					ma_q <= ly_q; mb_q <= GAIN_Q30; macc_q <= '0;
				end
				ST_ROT1: begin
					cx_q <= rot_flip ? -GAIN_Q30 : GAIN_Q30;
					cy_q <= '0;
					z_q  <= rot_flip ? rot_z0 + 32'h80000000 : rot_z0;
				end
				ST_ROT2: begin
					cx_q <= rot_flip ? -cx_q : cx_q;
					cy_q <= rot_flip ? -cy_q : cy_q;
					z_q  <= rot_flip ? rot_z0 + 32'h80000000 : rot_z0;
				end
				default: ;
			endcase
		end

		// engine steps
		if (unit_iter) begin
			if (is_rot) begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				z_q  <= z_n;
			end else if (is_div) begin
				macc_q <= div_ge ? div_diff[63:0] : div_t[63:0];
				ma_q   <= {ma_q[62:0], div_ge};
			end else if (is_cdiv) begin
				// right-shift multiply: high half in macc, low half enters mb
				macc_q <= mul_acc >> 1;
				mb_q   <= {mul_acc[0], mb_q[63:1]};
			end else begin
				macc_q <= mul_acc;
				ma_q   <= ma_q << 1;
				mb_q   <= mb_q >> 1;
			end
		end

		// results
		if (state_q == ST_PREP) begin
			df_q  <= 33'(fc_q) - 33'(last_fc_q);
			ds_q  <= 33'(sc_q) - 33'(last_sc_q);
			dh_q  <= 33'(hd_q) - 33'(last_hd_q);
			sum_q <= 33'(hd_q) + 33'(last_hd_q);
			// unchanged heading: raw wheel deltas
			lx_q  <= 64'(33'(sc_q) - 33'(last_sc_q));
			ly_q  <= 64'(33'(fc_q) - 33'(last_fc_q));
		end
		if (unit_done) begin
			unique case (state_q)
				ST_DIV_ANG:  ang_q  <= sum_q[32] ? 32'd0 - deg_q[31:0] : deg_q[31:0];
				ST_DIV_HALF: half_q <= dh_q[32] ? -$signed(deg_q) : $signed(deg_q);
				ST_ROT1: begin
					s_q <= cy_q;
					// half change rounded to zero: sin(h)/h taken as one
					if (half_q == '0) f_q <= ONE_Q30;
				end
				ST_FDIV:    f_q  <= sgn_q ? -$signed(ma_q) : $signed(ma_q);
				ST_MUL_DSF: lx_q <= $signed(macc_q) >>> TRIG_FRAC;
				ST_MUL_SO:  lx_q <= lx_q + ($signed(macc_q) >>> TRIG_FRAC);
				ST_MUL_DFF: ly_q <= $signed(macc_q) >>> TRIG_FRAC;
				ST_MUL_FO:  ly_q <= ly_q + ($signed(macc_q) >>> TRIG_FRAC);
				// gain compensation, then guard bits for the rotation
				ST_MUL_LX:  cx_q <= ($signed(macc_q) >>> TRIG_FRAC) <<< GUARD;
				ST_MUL_LY:  cy_q <= ($signed(macc_q) >>> TRIG_FRAC) <<< GUARD;
				default: ;
			endcase
		end
	end

	// a beat taken moves the sequencer out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready still high after an accepted beat");

	// engine step counter stays within the longest unit run
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DIV_ITERS + 1))
		else $error("engine step counter out of range");

	// a fresh result only appears from the hand-off state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the hand-off state");

endmodule

[sim/tb_arc_odometry_pose_tracker.sv]
// tb_arc_odometry_pose_tracker: self-checking testbench for the arc odometry pose tracker,
// with directed and random update / set-pose beats and config phases checked by a predictor;
// depends on aopt_pkg and rtl/arc_odometry_pose_tracker.sv
`timescale 1ns / 1ps

module tb_arc_odometry_pose_tracker;
	import aopt_pkg::*;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] h;
	} pose_t;

	// cordic angle table, atan(2^-i), full turn = 2^32
	localparam bit [31:0] ATAN_TBL [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};
	localparam longint K_GAIN  = 64'sd652032874;
	localparam longint K_TPP   = 64'sd683565276;
	localparam longint K_ONE   = 64'sd1073741824;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               in_op;
	logic signed [31:0] in_fwd;
	logic signed [31:0] in_side;
	logic signed [31:0] in_head;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading_out;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	arc_odometry_pose_tracker i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (in_op),
		.forward_count  (in_fwd),
		.sideways_count (in_side),
		.heading        (in_head),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.heading_out    (heading_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// predictor copy of registers and tracker state
	longint trk_fo, trk_so, trk_sx, trk_sy;
	longint trk_x, trk_y, trk_head, trk_fwd, trk_side;

	pose_t  pose_q[$];
	int     n_errors   = 0;
	int     n_beats    = 0;
	int     n_results  = 0;
	int     n_setpose  = 0;
	int     n_cfg      = 0;
	int     burst_left = 0;
	int     hold_cycles = 0;

	// clock and receiver
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// receiver stall pattern: modes change when a countdown runs out, a long hold overrides
	int rx_mode = 0;
	int rx_cnt  = 0;
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready   <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			if (rx_cnt == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_cnt  <= 50;
			end else begin
				rx_cnt <= rx_cnt - 1;
			end
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ~out_ready;
				default: out_ready <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	// result checker: compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin
		pose_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pose_q.size() == 0) begin
				$display("%0t: result beat with nothing pending x=%h y=%h h=%h",
					$time, pos_x, pos_y, heading_out);
				n_errors++;
			end else begin
				e = pose_q.pop_front();
				n_results++;
				if (pos_x !== e.x) begin
					$display("%0t: pos_x expected %h actual %h", $time, e.x, pos_x);
					n_errors++;
				end
				if (pos_y !== e.y) begin
					$display("%0t: pos_y expected %h actual %h", $time, e.y, pos_y);
					n_errors++;
				end
				if (heading_out !== e.h) begin
					$display("%0t: heading_out expected %h actual %h", $time, e.h, heading_out);
					n_errors++;
				end
			end
		end
	end

	function automatic longint sx(longint v, int w);
		longint m;
		m = (64'sd1 << w) - 1;
		v = v & m;
		if (v[w-1])
			v = v - (64'sd1 << w);
		return v;
	endfunction

	// degrees Q16.16 to binary angle units, halved by the 720 divisor
	function automatic longint half_deg_units(longint v);
		longint m, q;
		m = (v < 0) ? -v : v;
		q = ((m << DEG_SHIFT) + 360) / 720;
		return (v < 0) ? -q : q;
	endfunction

	task automatic cordic_rot(inout longint x, inout longint y, input bit [31:0] z);
		longint dx, dy, nx;
		bit [31:0] tmp;
		tmp = z + 32'h40000000;
		if (tmp[31]) begin
			x = -x;
			y = -y;
			z = z + 32'h80000000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z[31]) begin
				nx = x + dx;
				y  = y - dy;
				z  = z + ATAN_TBL[i];
			end else begin
				nx = x - dx;
				y  = y + dy;
				z  = z - ATAN_TBL[i];
			end
			x = nx;
		end
	endtask

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// advance tracker state by one accepted beat and return the pose it reports
	task automatic track_pose(input logic op, input longint fc, input longint sc,
		input longint hd, output pose_t p);
		longint df, ds, dh, lx, ly, rx, ry, ang, hlf, c, s, f;
		bit [31:0] z;
		if (op) begin
			trk_x = trk_sx;
			trk_y = trk_sy;
		end else begin
			df  = fc - trk_fwd;
			ds  = sc - trk_side;
			dh  = hd - trk_head;
			lx  = ds;
			ly  = df;
			ang = half_deg_units(trk_head + hd);
			if (dh != 0) begin
				hlf = half_deg_units(dh);
				c = K_GAIN;
				s = 0;
				f = K_ONE;
				cordic_rot(c, s, hlf[31:0]);
				if (hlf != 0)
					f = (s * K_TPP) / hlf;
				lx = ((ds * f) >>> 30) + ((2 * trk_so * s) >>> 30);
				ly = ((df * f) >>> 30) + ((2 * trk_fo * s) >>> 30);
			end
			rx = ((lx * K_GAIN) >>> 30) * (64'sd1 << GUARD);
			ry = ((ly * K_GAIN) >>> 30) * (64'sd1 << GUARD);
			z  = 32'd0 - ang[31:0];
			cordic_rot(rx, ry, z);
			trk_x = clamp32(trk_x + ((rx + (64'sd1 << (GUARD - 1))) >>> GUARD));
			trk_y = clamp32(trk_y + ((ry + (64'sd1 << (GUARD - 1))) >>> GUARD));
		end
		trk_head = hd;
		trk_fwd  = fc;
		trk_side = sc;
		p.x = trk_x[31:0];
		p.y = trk_y[31:0];
		p.h = trk_head[31:0];
	endtask

	// send one input beat; the sender works in bursts with random gaps
	task automatic send_beat(input logic op, input logic [31:0] fc, input logic [31:0] sc,
		input logic [31:0] hd);
		pose_t p;
		in_valid <= 1'b1;
		in_op    <= op;
		in_fwd   <= fc;
		in_side  <= sc;
		in_head  <= hd;
		do @(posedge clk); while (!in_ready);
		track_pose(op, sx(fc, 32), sx(sc, 32), sx(hd, 32), p);
		pose_q.push_back(p);
		n_beats++;
		if (op)
			n_setpose++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid   <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 6);
		end
	endtask

	// drop valid and wait until every predicted result has arrived
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pose_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// valid stays up across back to back writes; write_all drops it after the last
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		n_cfg++;
		case (idx)
			REG_FORWARD_OFFSET:  trk_fo = sx(data, 24);
			REG_SIDEWAYS_OFFSET: trk_so = sx(data, 24);
			REG_START_X:         trk_sx = sx(data, 32);
			REG_START_Y:         trk_sy = sx(data, 32);
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] fo, input logic [31:0] so,
		input logic [31:0] x0, input logic [31:0] y0);
		drain();
		write_reg(REG_FORWARD_OFFSET, fo);
		write_reg(REG_SIDEWAYS_OFFSET, so);
		write_reg(REG_START_X, x0);
		write_reg(REG_START_Y, y0);
		cfg_valid <= 1'b0;
	endtask

	// directed: reset state, unchanged heading, extremes, set-pose, saturation
	task automatic test_directed;
		send_beat(1'b0, 32'd0, 32'd0, 32'd0);
		send_beat(1'b0, 32'h0001_0000, 32'h0002_0000, 32'd0);
		send_beat(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h005A_0000);
		send_beat(1'b0, 32'h0005_0000, 32'h0001_0000, 32'h005A_0001);
		send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(1'b1, 32'd0, 32'd0, 32'hFFB4_0000);
		send_beat(1'b0, 32'hFFFF_0000, 32'h0000_8000, 32'h00B4_0000);
		send_beat(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_all(32'h007F_FFFF, 32'h0080_0000, 32'h7FFF_0000, 32'h8000_1000);
		send_beat(1'b1, 32'd0, 32'd0, 32'd0);
		send_beat(1'b0, 32'h4000_0000, 32'h4000_0000, 32'h0000_0000);
		send_beat(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0168_0000);
		send_beat(1'b0, 32'h0100_0000, 32'h8000_0000, 32'hFE98_0000);
		write_all(32'hFF80_0000, 32'h007F_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_beat(1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0001_0000);
		send_beat(1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0001_0001);
		send_beat(1'b0, 32'h8234_5678, 32'h1ABC_DEF0, 32'h8001_0001);
		send_beat(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
	endtask

	// one random beat: mostly plausible motion, with occasional noise and set-pose beats
	task automatic random_beat;
		logic [31:0] fc, sc, hd;
		int kind;
		kind = $urandom_range(0, 19);
		fc = trk_fwd[31:0] + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		sc = trk_side[31:0] + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		hd = trk_head[31:0];
		if (kind < 10)
			hd = trk_head[31:0] + $signed($urandom_range(0, 32'h00B4_0000)) - 32'sh005A_0000;
		else if (kind < 12)
			hd = trk_head[31:0] + $signed($urandom_range(0, 8)) - 4;
		else if (kind < 15) begin
			fc = $urandom;
			sc = $urandom;
			hd = $urandom;
		end
		send_beat(kind == 19 || kind == 18, fc, sc, hd);
	endtask

	task automatic test_random(input int n);
		repeat (n) random_beat();
	endtask

	// receiver holds off long while the sender keeps offering beats
	task automatic test_backpressure;
		hold_cycles = 3000;
		repeat (8) random_beat();
	endtask

	task automatic test_config_phases;
		write_all($urandom, $urandom, $urandom, $urandom);
		test_random(322);
		write_all(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		test_random(200);
		write_all(32'hFF80_0000, 32'hFF80_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		test_random(200);
		write_all(32'h007F_FFFF, 32'h007F_FFFF, 32'h8000_0000, 32'h8000_0000);
		test_random(200);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_op     = 1'b0;
		in_fwd    = '0;
		in_side   = '0;
		in_head   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FORWARD_OFFSET;
		cfg_data  = '0;
		trk_fo = 0; trk_so = 0; trk_sx = 0; trk_sy = 0;
		trk_x = 0; trk_y = 0; trk_head = 0; trk_fwd = 0; trk_side = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		drain();
		test_config_phases();

		drain();
		repeat (700) @(posedge clk);
		$display("covered %0d beats (%0d set-pose), %0d results, %0d register writes",
			n_beats, n_setpose, n_results, n_cfg);
		if (n_errors == 0 && pose_q.size() == 0)
			$display("arc_odometry_pose_tracker: match");
		else
			$display("arc_odometry_pose_tracker: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#(60_000_000);
		$display("timeout with %0d results pending", pose_q.size());
		$display("arc_odometry_pose_tracker: mismatch");
		$finish;
	end

endmodule
